// ===== src/bfr_pkg.sv =====
// Shared types and constants for the battery frame receiver.
`timescale 1ns / 1ps

package bfr_pkg;

  localparam logic [15:0] SYNC_WORD     = 16'h55AA;
  localparam logic [7:0]  TYPE_STATUS   = 8'h07;
  localparam logic [8:0]  LEN_STATUS_A  = 9'd156;
  localparam logic [8:0]  LEN_STATUS_B  = 9'd153;
  localparam logic [8:0]  LEN_SWITCH    = 9'd6;
  localparam logic [7:0]  SW_CHARGE     = 8'h65;
  localparam logic [7:0]  SW_DISCHARGE  = 8'h66;

  localparam int BFR_QUEUE_DEPTH = 2;

  // frame kinds, also used as data_kind for the two status layouts
  localparam logic [1:0] KIND_OTHER    = 2'd0;
  localparam logic [1:0] KIND_STATUS_A = 2'd1;
  localparam logic [1:0] KIND_STATUS_B = 2'd2;
  localparam logic [1:0] KIND_SWITCH   = 2'd3;

  // switch frame target
  localparam logic [1:0] SW_SEL_NONE      = 2'd0;
  localparam logic [1:0] SW_SEL_CHARGE    = 2'd1;
  localparam logic [1:0] SW_SEL_DISCHARGE = 2'd2;

  // one finished frame, classified, handed from front to back
  typedef struct packed {
    logic [1:0]         kind;
    logic               ok;
    logic signed [15:0] voltage;
    logic [7:0]         soc;
    logic signed [15:0] bat_cur;
    logic signed [15:0] pv_cur;
    logic [7:0]         temp;
    logic [1:0]         sw_sel;
    logic               sw_flag;
  } frame_rec_t;

endpackage

// ===== src/bfr_front.sv =====
// Byte parser: header sync, length, checksum and field capture per frame.
`timescale 1ns / 1ps

module bfr_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [7:0]        rx_byte,
  output logic              rec_valid,
  output bfr_pkg::frame_rec_t rec
);
  import bfr_pkg::*;

  localparam logic [8:0] POS_A_SOC   = 9'd59;
  localparam logic [8:0] POS_A_VHI   = 9'd62;
  localparam logic [8:0] POS_A_VLO   = 9'd63;
  localparam logic [8:0] POS_A_IHI   = 9'd66;
  localparam logic [8:0] POS_A_ILO   = 9'd67;
  localparam logic [8:0] POS_B_SOC   = 9'd122;
  localparam logic [8:0] POS_B_VHI   = 9'd123;
  localparam logic [8:0] POS_B_VLO   = 9'd124;
  localparam logic [8:0] POS_B_IHI   = 9'd125;
  localparam logic [8:0] POS_B_ILO   = 9'd126;
  localparam logic [8:0] POS_B_TEMP  = 9'd136;
  localparam logic [8:0] POS_B_PVHI  = 9'd150;
  localparam logic [8:0] POS_B_PVLO  = 9'd151;
  localparam logic [8:0] POS_SW_CODE = 9'd0;
  localparam logic [8:0] POS_SW_VAL  = 9'd4;

  logic [2:0]  hdr_pos;
  logic        in_payload;
  logic [8:0]  pay_pos;
  logic [8:0]  pay_len;
  logic [15:0] sync;
  logic [7:0]  ftype;
  logic [7:0]  sum;

  logic [7:0]  a_soc, b_soc, b_temp, sw_code, sw_val;
  logic [15:0] a_volt, a_cur, b_volt, b_cur, b_pv;

  logic        last;
  logic [1:0]  kind;

  assign last = ({1'b0, pay_pos} + 10'd1) >= {1'b0, pay_len};

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_pos    <= '0;
      in_payload <= 1'b0;
      pay_pos    <= '0;
      pay_len    <= '0;
      sync       <= '0;
      ftype      <= '0;
      sum        <= '0;
    end else if (in_valid) begin
      if (!in_payload) begin
        case (hdr_pos)
          3'd0: begin
            sync <= {rx_byte, 8'h00};
          end
          3'd1: begin
            sync[7:0] <= rx_byte;
          end
          3'd3: begin
            ftype <= rx_byte;
          end
          default: ;
        endcase
        if (hdr_pos == 3'd0) begin
          sum <= '0;
        end else if (hdr_pos >= 3'd2) begin
          sum <= sum + rx_byte;
        end
        if (hdr_pos >= 3'd5) begin
          hdr_pos <= '0;
          if (sync == SYNC_WORD) begin
            in_payload <= 1'b1;
            pay_len    <= {1'b0, rx_byte} + 9'd1;
            pay_pos    <= '0;
          end
        end else begin
          hdr_pos <= hdr_pos + 3'd1;
        end
      end else if (!last) begin
        sum     <= sum + rx_byte;
        pay_pos <= pay_pos + 9'd1;
      end else begin
        in_payload <= 1'b0;
        pay_pos    <= '0;
      end
    end
  end

  // capture the payload bytes that decoding needs
  always_ff @(posedge clk) begin
    if (in_valid && in_payload) begin
      case (pay_pos)
        POS_A_SOC:   a_soc        <= rx_byte;
        POS_A_VHI:   a_volt[15:8] <= rx_byte;
        POS_A_VLO:   a_volt[7:0]  <= rx_byte;
        POS_A_IHI:   a_cur[15:8]  <= rx_byte;
        POS_A_ILO:   a_cur[7:0]   <= rx_byte;
        POS_B_SOC:   b_soc        <= rx_byte;
        POS_B_VHI:   b_volt[15:8] <= rx_byte;
        POS_B_VLO:   b_volt[7:0]  <= rx_byte;
        POS_B_IHI:   b_cur[15:8]  <= rx_byte;
        POS_B_ILO:   b_cur[7:0]   <= rx_byte;
        POS_B_TEMP:  b_temp       <= rx_byte;
        POS_B_PVHI:  b_pv[15:8]   <= rx_byte;
        POS_B_PVLO:  b_pv[7:0]    <= rx_byte;
        POS_SW_CODE: sw_code      <= rx_byte;
        POS_SW_VAL:  sw_val       <= rx_byte;
        default: ;
      endcase
    end
  end

  always_comb begin
    kind = KIND_OTHER;
    if (ftype == TYPE_STATUS) begin
      if (pay_len == LEN_STATUS_A) begin
        kind = KIND_STATUS_A;
      end else if (pay_len == LEN_STATUS_B) begin
        kind = KIND_STATUS_B;
      end else if (pay_len == LEN_SWITCH) begin
        kind = KIND_SWITCH;
      end
    end
  end

  always_comb begin
    rec_valid   = in_valid && in_payload && last;
    rec.kind    = kind;
    rec.ok      = (rx_byte == (sum - 8'd1));
    rec.voltage = '0;
    rec.soc     = '0;
    rec.bat_cur = '0;
    rec.pv_cur  = '0;
    rec.temp    = '0;
    case (kind)
      KIND_STATUS_A: begin
        rec.voltage = a_volt;
        rec.soc     = a_soc;
        rec.bat_cur = a_cur;
      end
      KIND_STATUS_B: begin
        rec.voltage = b_volt;
        rec.soc     = b_soc;
        rec.bat_cur = b_cur;
        rec.pv_cur  = b_pv;
        rec.temp    = b_temp;
      end
      default: ;
    endcase
    if (sw_code == SW_CHARGE) begin
      rec.sw_sel = SW_SEL_CHARGE;
    end else if (sw_code == SW_DISCHARGE) begin
      rec.sw_sel = SW_SEL_DISCHARGE;
    end else begin
      rec.sw_sel = SW_SEL_NONE;
    end
    rec.sw_flag = (sw_val == 8'd1);
  end

endmodule

// ===== src/bfr_queue.sv =====
// Small FIFO of finished frame records between parser and decoder.
`timescale 1ns / 1ps

module bfr_queue #(
  parameter int DEPTH = bfr_pkg::BFR_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  bfr_pkg::frame_rec_t wr_data,
  input  logic                rd_en,
  output bfr_pkg::frame_rec_t rd_data,
  output logic                full,
  output logic                empty
);
  import bfr_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  frame_rec_t    entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/bfr_back.sv =====
// Decoder: applies frame records to the held battery data, drives results.
`timescale 1ns / 1ps

module bfr_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  bfr_pkg::frame_rec_t q_data,
  output logic                q_rd,
  input  logic                pop,
  output logic                empty,
  output logic [1:0]          frame_kind,
  output logic                checksum_ok,
  output logic                keepalive,
  output logic                data_updated,
  output logic signed [15:0]  voltage_tenths,
  output logic [7:0]          state_of_charge,
  output logic signed [15:0]  battery_current_tenths,
  output logic signed [15:0]  pv_current_tenths,
  output logic [7:0]          temperature,
  output logic                charge_enabled,
  output logic                discharge_enabled,
  output logic [1:0]          data_kind
);
  import bfr_pkg::*;

  logic out_valid;
  logic is_status;
  logic is_switch;

  assign empty = !out_valid;
  assign q_rd  = !q_empty && (!out_valid || pop);

  assign is_status = q_data.ok &&
                     (q_data.kind == KIND_STATUS_A || q_data.kind == KIND_STATUS_B);
  assign is_switch = q_data.ok && (q_data.kind == KIND_SWITCH) &&
                     (q_data.sw_sel != SW_SEL_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_rd) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      frame_kind   <= q_data.kind;
      checksum_ok  <= q_data.ok;
      keepalive    <= (q_data.kind == KIND_STATUS_A);
      data_updated <= is_status || is_switch;
    end
  end

  // held data doubles as the result fields; it only moves when a new
  // result is loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      voltage_tenths         <= '0;
      state_of_charge        <= '0;
      battery_current_tenths <= '0;
      pv_current_tenths      <= '0;
      temperature            <= '0;
      charge_enabled         <= 1'b0;
      discharge_enabled      <= 1'b0;
      data_kind              <= '0;
    end else if (q_rd) begin
      if (is_status) begin
        voltage_tenths         <= q_data.voltage;
        state_of_charge        <= q_data.soc;
        battery_current_tenths <= q_data.bat_cur;
        pv_current_tenths      <= q_data.pv_cur;
        temperature            <= q_data.temp;
        data_kind              <= q_data.kind;
      end
      if (is_switch) begin
        if (q_data.sw_sel == SW_SEL_CHARGE) begin
          charge_enabled <= q_data.sw_flag;
        end else begin
          discharge_enabled <= q_data.sw_flag;
        end
      end
    end
  end

endmodule

// ===== src/battery_frame_receiver.sv =====
// Top level of the battery frame receiver.
`timescale 1ns / 1ps

// Takes one received byte per push and gives one result per kept frame, on the
// frame's last payload byte. A byte is taken every cycle while full is low; full
// rises only when the frame queue between parser and decoder (QUEUE_DEPTH records)
// fills up because results are not being popped. When nothing waits ahead of it,
// a result is written into the frame queue with the frame's last byte and is then
// loaded into the result registers, from where it can be popped. It stays until
// popped. The held battery fields reflect every frame up to and including the one
// shown.
module battery_frame_receiver #(
  parameter int QUEUE_DEPTH = bfr_pkg::BFR_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         rx_byte,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         frame_kind,
  output logic               checksum_ok,
  output logic               keepalive,
  output logic               data_updated,
  output logic signed [15:0] voltage_tenths,
  output logic [7:0]         state_of_charge,
  output logic signed [15:0] battery_current_tenths,
  output logic signed [15:0] pv_current_tenths,
  output logic [7:0]         temperature,
  output logic               charge_enabled,
  output logic               discharge_enabled,
  output logic [1:0]         data_kind
);
  import bfr_pkg::*;

  logic       accept;
  logic       rec_valid;
  frame_rec_t rec;
  frame_rec_t q_data;
  logic       q_empty;
  logic       q_rd;

  assign accept = push && !full;

  bfr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .rx_byte   (rx_byte),
    .rec_valid (rec_valid),
    .rec       (rec)
  );

  bfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (rec_valid),
    .wr_data (rec),
    .rd_en   (q_rd),
    .rd_data (q_data),
    .full    (full),
    .empty   (q_empty)
  );

  bfr_back u_back (
    .clk                    (clk),
    .rst                    (rst),
    .q_empty                (q_empty),
    .q_data                 (q_data),
    .q_rd                   (q_rd),
    .pop                    (pop),
    .empty                  (empty),
    .frame_kind             (frame_kind),
    .checksum_ok            (checksum_ok),
    .keepalive              (keepalive),
    .data_updated           (data_updated),
    .voltage_tenths         (voltage_tenths),
    .state_of_charge        (state_of_charge),
    .battery_current_tenths (battery_current_tenths),
    .pv_current_tenths      (pv_current_tenths),
    .temperature            (temperature),
    .charge_enabled         (charge_enabled),
    .discharge_enabled      (discharge_enabled),
    .data_kind              (data_kind)
  );

endmodule
